// ===== design/sptq_pkg.sv =====
// Package with the shared constants, types and helper functions of the task queue block.
package sptq_pkg;

	localparam int LEVELS      = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int HANDLE_BITS = 16;

	localparam int NUM_FIFOS   = LEVELS + 1;
	localparam int URGENT_IDX  = LEVELS;
	localparam int STORE_DEPTH = NUM_FIFOS * QUEUE_DEPTH;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CLS_W  = 4;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int TOP_W  = 3;
	localparam int PRI_W  = 8;
	localparam int STAT_W = 2;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 32;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
	} dp_stat_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (int'(p) == QUEUE_DEPTH - 1) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== design/sptq_if.sv =====
// Handshake interfaces for the request and response channels.
interface sptq_req_if import sptq_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic signed [PRI_W-1:0]       priority_req;
	logic        [HANDLE_BITS-1:0] task_handle;

	modport source (output valid, output cmd, output priority_req, output task_handle,
		input ready);
	modport sink (input valid, input cmd, input priority_req, input task_handle,
		output ready);
endinterface

interface sptq_rsp_if import sptq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STAT_W-1:0]      status;
	logic [HANDLE_BITS-1:0] task_out;
	logic [CLS_W-1:0]       served_class;

	modport source (output valid, output status, output task_out, output served_class,
		input ready);
	modport sink (input valid, input status, input task_out, input served_class,
		output ready);
endinterface

// ===== design/strict_priority_task_queues.sv =====
// Top level of the strict priority task queues: configuration register and unit wiring.
//
//  Channel | Direction | Content
//  --------+-----------+-------------------------------------------------
//  req     | sink      | cmd, priority_req, task_handle (valid/ready)
//  rsp     | source    | status, task_out, served_class (valid/ready)
//  apb     | slave     | top_level at byte address 0
//
// The accept cycle selects the queue and reads the handle store; the commit, which waits
// for a free response register, writes the store and updates the pointers and counts.
// Requests are taken one at a time; a new one is accepted while the previous
// response still waits in the output register, but it is not committed until that
// response is taken. Reset clears all pointers and counts at once; the store is not reset.
module strict_priority_task_queues import sptq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sptq_req_if.sink          req,
	sptq_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	logic [TOP_W-1:0] top_level_q;
	logic             cfg_wr;
	ctrl_cmd_t        cmd;
	dp_stat_t         stat;
	logic             req_ready;

	// The only register sits at byte address 0.
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_level_q <= '0;
		end else if (cfg_wr) begin
			top_level_q <= pwdata[TOP_W-1:0];
		end
	end

	assign prdata = CFG_DW'(top_level_q);
	assign pready = 1'b1;

	sptq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	assign req.ready = req_ready;

	sptq_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.top_level    (top_level_q),
		.req_cmd      (req.cmd),
		.req_priority (req.priority_req),
		.req_handle   (req.task_handle),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.rsp_status   (rsp.status),
		.rsp_task     (rsp.task_out),
		.rsp_class    (rsp.served_class)
	);

endmodule

// ===== design/sptq_ctrl.sv =====
// Controller state machine: takes one request, then commits it into the response register.
module sptq_ctrl import sptq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// Hold the staged transaction until the response register can take it.
				if (stat.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/sptq_dpath.sv =====
// Datapath: queue pointers, fill counts, handle store, queue selection and response register.
module sptq_dpath import sptq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               cmd,
	output dp_stat_t                stat,
	input  logic [TOP_W-1:0]        top_level,
	input  logic                    req_cmd,
	input  logic signed [PRI_W-1:0] req_priority,
	input  logic [HANDLE_BITS-1:0]  req_handle,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic [STAT_W-1:0]       rsp_status,
	output logic [HANDLE_BITS-1:0]  rsp_task,
	output logic [CLS_W-1:0]        rsp_class
);

	logic [PTR_W-1:0] head_q [NUM_FIFOS];
	logic [PTR_W-1:0] tail_q [NUM_FIFOS];
	logic [CNT_W-1:0] fill_q [NUM_FIFOS];

	logic [HANDLE_BITS-1:0] store_q [STORE_DEPTH];

	logic                   enq_s1;
	logic [CLS_W-1:0]       q_s1;
	logic [STAT_W-1:0]      status_s1;
	logic [HANDLE_BITS-1:0] handle_s1;
	logic [HANDLE_BITS-1:0] rdata_s1;

	logic                   rsp_valid_q;
	logic [STAT_W-1:0]      rsp_status_q;
	logic [HANDLE_BITS-1:0] rsp_task_q;
	logic [CLS_W-1:0]       rsp_class_q;

	logic [CLS_W-1:0]  top_eff;
	logic [PRI_W-2:0]  pri_mag;
	logic [CLS_W-1:0]  enq_q;
	logic [CLS_W-1:0]  deq_q;
	logic              deq_found;
	logic [CLS_W-1:0]  sel_q;
	logic [STAT_W-1:0] sel_status;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              do_update;

	// Enqueue target: urgent on negative priority, else clamp to the effective top level.
	always_comb begin
		pri_mag = req_priority[PRI_W-2:0];
		if (int'(top_level) >= LEVELS) begin
			top_eff = CLS_W'(LEVELS - 1);
		end else begin
			top_eff = CLS_W'(top_level);
		end
		if (req_priority[PRI_W-1]) begin
			enq_q = CLS_W'(URGENT_IDX);
		end else if (int'(pri_mag) > int'(top_eff)) begin
			enq_q = top_eff;
		end else begin
			enq_q = CLS_W'(pri_mag);
		end
	end

	// Dequeue source: urgent first, then the highest ordinary level that holds anything.
	always_comb begin
		deq_q     = '0;
		deq_found = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (fill_q[i] != '0) begin
				deq_q     = CLS_W'(i);
				deq_found = 1'b1;
			end
		end
		if (fill_q[URGENT_IDX] != '0) begin
			deq_q     = CLS_W'(URGENT_IDX);
			deq_found = 1'b1;
		end
	end

	always_comb begin
		if (req_cmd == CMD_ENQ) begin
			sel_q = enq_q;
			if (fill_q[enq_q] == CNT_W'(QUEUE_DEPTH)) begin
				sel_status = STAT_FULL;
			end else begin
				sel_status = STAT_DONE;
			end
		end else begin
			sel_q      = deq_q;
			sel_status = deq_found ? STAT_DONE : STAT_EMPTY;
		end
		rd_addr = ADDR_W'(int'(deq_q) * QUEUE_DEPTH) + ADDR_W'(head_q[deq_q]);
		wr_addr = ADDR_W'(int'(q_s1) * QUEUE_DEPTH) + ADDR_W'(tail_q[q_s1]);
	end

	assign do_update = cmd.commit && (status_s1 == STAT_DONE);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			enq_s1    <= (req_cmd == CMD_ENQ);
			q_s1      <= sel_q;
			status_s1 <= sel_status;
			handle_s1 <= req_handle;
			rdata_s1  <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (do_update && enq_s1) begin
			store_q[wr_addr] <= handle_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FIFOS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (do_update) begin
			if (enq_s1) begin
				tail_q[q_s1] <= next_ptr(tail_q[q_s1]);
				fill_q[q_s1] <= fill_q[q_s1] + CNT_W'(1);
			end else begin
				head_q[q_s1] <= next_ptr(head_q[q_s1]);
				fill_q[q_s1] <= fill_q[q_s1] - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_status_q <= status_s1;
			rsp_class_q  <= q_s1;
			if (!enq_s1 && status_s1 == STAT_DONE) begin
				rsp_task_q <= rdata_s1;
			end else begin
				rsp_task_q <= '0;
			end
		end
	end

	assign stat.slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid      = rsp_valid_q;
	assign rsp_status     = rsp_status_q;
	assign rsp_task       = rsp_task_q;
	assign rsp_class      = rsp_class_q;

endmodule

// ===== design/sptq_chk.sv =====
// Port-level checker for the strict priority task queues, bound to the top level.
module sptq_chk import sptq_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [STAT_W-1:0]      rsp_status,
	input logic [HANDLE_BITS-1:0] rsp_task,
	input logic [CLS_W-1:0]       rsp_class
);

	// One request at a time: after a transaction on the request side, ready drops.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted in the cycle after another one");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_task) && $stable(rsp_class))
		else $error("stalled response changed");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_EMPTY |-> rsp_task == '0 && rsp_class == '0)
		else $error("empty response carries a handle or class");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STAT_DONE || rsp_status == STAT_FULL ||
			rsp_status == STAT_EMPTY) && int'(rsp_class) <= URGENT_IDX)
		else $error("response status or class out of range");

	a_full_no_task: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_FULL |-> rsp_task == '0)
		else $error("rejected enqueue returned a handle");

endmodule

bind strict_priority_task_queues sptq_chk u_sptq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_task   (rsp.task_out),
	.rsp_class  (rsp.served_class)
);
